FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the positional list engine modules.
// Expects signals named clock and reset (synchronous, active high) in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/ple_pkg.sv
// Shared types and constants of the positional list engine.
// No dependencies; imported by every module of the block except ple_ram.
package ple_pkg;

   localparam int DEPTH_DEF  = 64;
   localparam int DATA_W_DEF = 32;

   localparam int OP_W    = 3;
   localparam int POS_W   = 7;
   localparam int ST_W    = 2;
   localparam int COUNT_W = 7;
   localparam int FIELD_W = 32;

   localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
   localparam logic [OP_W-1:0] OP_REPLACE = 3'd2;
   localparam logic [OP_W-1:0] OP_READ    = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

   localparam logic [ST_W-1:0] ST_OK     = 2'd0;
   localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [POS_W-1:0]   position;
      logic [FIELD_W-1:0] data_in;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]    status;
      logic [COUNT_W-1:0] entry_count;
      logic [FIELD_W-1:0] data_out;
   } rsp_type;

   // What an accepted item still needs after the accept cycle
   typedef enum logic [1:0] {
      JOB_DONE,
      JOB_READ,
      JOB_INSERT,
      JOB_DELETE
   } job_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_INS_SHIFT,
      S_INS_WRITE,
      S_DEL_SHIFT
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic ins_step;
      logic ins_fill;
      logic del_step;
      logic rd_capture;
      logic resp_set;
   } ctrl_cmd_type;

   typedef struct packed {
      job_type job;
      logic    ins_last;
      logic    del_last;
      logic    out_free;
   } dp_sts_type;

endpackage

FILE: hw/rtl/ple_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/ple_datapath.sv
// Datapath of the positional list engine: decode, count, sweep index,
// entry RAM and result register. Uses ple_pkg, ple_ram, assert_macros.svh.
`include "assert_macros.svh"

module ple_datapath
   import ple_pkg::*;
#(
   parameter int DEPTH  = DEPTH_DEF,
   parameter int DATA_W = DATA_W_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  req_type      req_item,
   input  logic         rsp_stall,
   input  ctrl_cmd_type cmd,
   output dp_sts_type   sts,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     idx_ff, pos_ff;
   logic [DATA_W-1:0] word_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   logic [CMPW-1:0]   pos_x, cnt_x;
   logic [AW-1:0]     pos_a;
   logic [DATA_W-1:0] word_in;
   logic [ST_W-1:0]   status_d;
   job_type           job_d;
   logic              wr_now;

   logic              ram_wr_en, ram_rd_en;
   logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
   logic [DATA_W-1:0] ram_wr_data, ram_rd_data;

   assign pos_x   = CMPW'(req_item.position);
   assign cnt_x   = CMPW'(count_ff);
   assign pos_a   = AW'(req_item.position);
   assign word_in = DATA_W'(req_item.data_in);

   // Item decode against the current count
   always_comb begin
      status_d = ST_OK;
      count_in = count_ff;
      job_d    = JOB_DONE;
      wr_now   = 1'b0;
      unique case (req_item.op)
         OP_INSERT: begin
            if (pos_x > cnt_x) begin
               status_d = ST_BADPOS;
            end else if (count_ff == CW'(DEPTH)) begin
               status_d = ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
               if (pos_x == cnt_x) begin
                  wr_now = 1'b1;       // append, nothing to move
               end else begin
                  job_d = JOB_INSERT;
               end
            end
         end
         OP_DELETE: begin
            if (pos_x >= cnt_x) begin
               status_d = ST_BADPOS;
            end else begin
               count_in = count_ff - 1'b1;
               if (pos_x + 1'b1 != cnt_x) begin
                  job_d = JOB_DELETE;  // last entry goes without a move
               end
            end
         end
         OP_REPLACE: begin
            if (pos_x >= cnt_x) begin
               status_d = ST_BADPOS;
            end else begin
               wr_now = 1'b1;
            end
         end
         OP_READ: begin
            if (pos_x >= cnt_x) begin
               status_d = ST_BADPOS;
            end else begin
               job_d = JOB_READ;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            status_d = ST_BADPOS;
         end
      endcase
   end

   // Sweep ends: insert moves downwards to pos+1, delete upwards to count-1
   assign sts.job      = job_d;
   assign sts.ins_last = (idx_ff == pos_ff + 1'b1);
   assign sts.del_last = ((CW'(idx_ff) + 1'b1) == count_ff);
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   // RAM write port
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = pos_a;
      ram_wr_data = word_in;
      priority if (cmd.accept && wr_now) begin
         ram_wr_en = 1'b1;
      end else if (cmd.ins_step || cmd.del_step) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = idx_ff;
         ram_wr_data = ram_rd_data;
      end else if (cmd.ins_fill) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = pos_ff;
         ram_wr_data = word_ff;
      end else begin
         ram_wr_en = 1'b0;
      end
   end

   // RAM read port: reads run one entry ahead of the write
   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = pos_a;
      priority if (cmd.accept) begin
         unique case (job_d)
            JOB_READ: begin
               ram_rd_en = 1'b1;
            end
            JOB_INSERT: begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(count_ff - 1'b1);
            end
            JOB_DELETE: begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = pos_a + 1'b1;
            end
            JOB_DONE: begin
               ram_rd_en = 1'b0;
            end
         endcase
      end else if (cmd.ins_step) begin
         ram_rd_en   = !sts.ins_last;
         ram_rd_addr = idx_ff - AW'(2);
      end else if (cmd.del_step) begin
         ram_rd_en   = !sts.del_last;
         ram_rd_addr = idx_ff + AW'(2);
      end else begin
         ram_rd_en = 1'b0;
      end
   end

   ple_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            count_ff <= count_in;
         end
         if (cmd.resp_set) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pos_ff               <= pos_a;
         word_ff              <= word_in;
         idx_ff               <= (job_d == JOB_INSERT) ? AW'(count_ff) : pos_a;
         rsp_ff.status        <= status_d;
         rsp_ff.entry_count   <= COUNT_W'(count_in);
         rsp_ff.data_out      <= '0;
      end else if (cmd.ins_step) begin
         idx_ff <= idx_ff - 1'b1;
      end else if (cmd.del_step) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.rd_capture) begin
         rsp_ff.data_out <= FIELD_W'(ram_rd_data);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(DEPTH), "entry count above depth")
   `ASSERT_IMPLIES(a_port_clash, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr,
      "RAM read and write hit the same entry")

endmodule

FILE: hw/rtl/ple_ctrl.sv
// Controller of the positional list engine: sequences accept, read and
// shift sweeps. Uses ple_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ple_ctrl
   import ple_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  dp_sts_type   sts,
   output logic         req_stall,
   output ctrl_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall  = !sts.out_free;
            cmd.accept = req_valid && sts.out_free;
            if (cmd.accept) begin
               unique case (sts.job)
                  JOB_DONE:   cmd.resp_set = 1'b1;
                  JOB_READ:   state_in = S_READ;
                  JOB_INSERT: state_in = S_INS_SHIFT;
                  JOB_DELETE: state_in = S_DEL_SHIFT;
               endcase
            end
         end
         S_READ: begin
            cmd.rd_capture = 1'b1;
            cmd.resp_set   = 1'b1;
            state_in       = S_IDLE;
         end
         S_INS_SHIFT: begin
            cmd.ins_step = 1'b1;
            if (sts.ins_last) begin
               state_in = S_INS_WRITE;
            end
         end
         S_INS_WRITE: begin
            cmd.ins_fill = 1'b1;
            cmd.resp_set = 1'b1;
            state_in     = S_IDLE;
         end
         S_DEL_SHIFT: begin
            cmd.del_step = 1'b1;
            if (sts.del_last) begin
               cmd.resp_set = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `ASSERT_IMPLIES(a_resp_slot_free, cmd.resp_set, sts.out_free,
      "result loaded while the output register still holds one")

endmodule

FILE: hw/rtl/positional_list_engine_unit.sv
// Top level of the positional list engine. Uses ple_pkg, ple_ctrl and
// ple_datapath (which holds the ple_ram entry store).

// Ordered list of up to DEPTH words of DATA_W bits, held in a simple
// dual-port RAM. Each accepted item gives exactly one result item with the
// status, the entry count after the operation and, for a good read, the
// entry. Clear, replace, a refused item, an insert at the end and a delete
// of the last entry finish in the accept cycle; a read waits in S_READ for
// the registered RAM read; an insert that moves entries sweeps in S_INS_SHIFT,
// then writes the new entry in S_INS_WRITE; a delete that moves entries
// sweeps in S_DEL_SHIFT. No new item is taken before the last is done. The
// moves are set by the RAM's single write port, one entry per cycle, with
// the read running one entry ahead. A new item is taken only once the
// output register is empty or being emptied in that cycle.
// Entries are not cleared at reset or by clear; only the count is. No
// clearing pass is needed, so items are taken straight after reset.
module positional_list_engine_unit
   import ple_pkg::*;
#(
   parameter int DEPTH  = DEPTH_DEF,   // 2 to 127 entries
   parameter int DATA_W = DATA_W_DEF   // 1 to 32 bits per entry
) (
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   // result channel
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   // sequencing: accept, read wait, shift sweeps
   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // decode, count, entry store and result register
   ple_datapath #(
      .DEPTH  (DEPTH),
      .DATA_W (DATA_W)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
